// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the downscaler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hdl/ibd_pkg.sv =====
// Package for the image block downscaler: constants, register indices and types.
package ibd_pkg;
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_FACTOR_DEF = 16;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int SUM_W          = 16;
	localparam int GAUSS_FACTOR   = 3;
	localparam int GAUSS_SHIFT    = 4;

	localparam logic [1:0] REG_COLOR  = 2'd0;
	localparam logic [1:0] REG_FACTOR = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV
	} ibd_state_t;

	typedef struct packed {
		logic load;      // capture input word and position
		logic update;    // write sum, decide output
		logic div_start; // begin divide
	} ibd_cmd_t;

	typedef struct packed {
		logic in_block;  // pixel lies in a complete block
		logic emit;      // block finished
		logic div_done;
		logic out_busy;  // output register full and stalled
		logic sizing;    // block limits being sized
	} ibd_stat_t;
endpackage

// ===== hdl/ibd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ibd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/ibd_ctrl.sv =====
// Controller state machine for the downscaler.
module ibd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output ibd_pkg::ibd_cmd_t cmd,
	input  ibd_pkg::ibd_stat_t stat
);
	import ibd_pkg::*;
	`include "assert_macros.svh"

	ibd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				// hold off pixels while block limits are being sized
				in_stall = stat.sizing;
				if (in_valid && !stat.sizing) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!(stat.emit && stat.out_busy)) begin
					cmd.update = 1'b1;
					if (stat.emit) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_NEXT(a_load_read, clk, arst_n, cmd.load, state_q == ST_READ, "load not followed by read")
	`ASSERT_IMPL(a_stall_busy, clk, arst_n, (state_q != ST_IDLE) |-> in_stall, "accept while busy")
	`ASSERT_IMPL(a_div_emit, clk, arst_n, cmd.div_start |-> stat.emit, "divide without block end")
endmodule

// ===== hdl/ibd_dp.sv =====
// Datapath: position counters, column sums, divider and output register.
module ibd_dp #(
	parameter int MAX_WIDTH  = ibd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = ibd_pkg::MAX_FACTOR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [12:0]        cfg_data,
	input  logic [7:0]         red_or_gray,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  ibd_pkg::ibd_cmd_t  cmd,
	output ibd_pkg::ibd_stat_t stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_red_or_gray,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic               frame_last
);
	import ibd_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int DW = 2 * FW;

	// configuration
	logic        color_q;
	logic [4:0]  factor_q;
	logic [12:0] width_q, height_q;

	// effective values
	logic [FW-1:0] f_eff;
	logic [13:0]   w_eff, h_eff;
	logic          gauss, rgb;

	always_comb begin
		if (factor_q == 5'd0) begin
			f_eff = FW'(1);
		end else if (32'(factor_q) > MAX_FACTOR) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(factor_q);
		end
		if (width_q == 13'd0) begin
			w_eff = 14'd1;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = 14'(MAX_WIDTH);
		end else begin
			w_eff = 14'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = 14'd1;
		end else if (32'(height_q) > HEIGHT_LIMIT) begin
			h_eff = 14'(HEIGHT_LIMIT);
		end else begin
			h_eff = 14'(height_q);
		end
		gauss = (f_eff == FW'(GAUSS_FACTOR));
		rgb   = color_q;
	end

	// position: column, row, offsets within block, block column index
	logic [11:0]   col_q, row_q;
	logic [3:0]    rib_q;
	logic [FW-1:0] coff_q, roff_q; // coff tracks col % f, roff tracks row % f
	logic [AW-1:0] oc_q;           // col / f
	logic [13:0]   ocnt_q;         // row / f
	logic [13:0]   colend_q, rowend_q; // out_w*f and out_h*f, computed by stepping
	logic [13:0]   ow_q, oh_q;

	// Limits: find out_w*f by tracking last full block start as the image is swept is awkward;
	// compute with a small iterative unit after config instead.
	logic [13:0] lim_acc_q;
	logic [13:0] lim_cnt_q;
	logic        lim_busy_q, lim_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= 1'b0;
			factor_q    <= 5'd2;
			width_q     <= 13'd1;
			height_q    <= 13'd1;
			lim_busy_q  <= 1'b1;
			lim_phase_q <= 1'b0;
			lim_acc_q   <= '0;
			lim_cnt_q   <= '0;
			colend_q    <= '0;
			rowend_q    <= '0;
			ow_q        <= '0;
			oh_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COLOR:  color_q  <= cfg_data[0];
				REG_FACTOR: factor_q <= cfg_data[4:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			lim_busy_q  <= 1'b1;
			lim_phase_q <= 1'b0;
			lim_acc_q   <= '0;
			lim_cnt_q   <= '0;
		end else if (lim_busy_q) begin
			// count whole blocks that fit: add f until exceeding the extent
			if (lim_acc_q + 14'(f_eff) <= (lim_phase_q ? h_eff : w_eff)) begin
				lim_acc_q <= lim_acc_q + 14'(f_eff);
				lim_cnt_q <= lim_cnt_q + 14'd1;
			end else if (!lim_phase_q) begin
				colend_q    <= lim_acc_q;
				ow_q        <= lim_cnt_q;
				lim_phase_q <= 1'b1;
				lim_acc_q   <= '0;
				lim_cnt_q   <= '0;
			end else begin
				rowend_q   <= lim_acc_q;
				oh_q       <= lim_cnt_q;
				lim_busy_q <= 1'b0;
			end
		end
	end

	assign stat.sizing = lim_busy_q;

	// captured pixel
	logic [7:0] px_q [3];
	logic       inb_q, first_q, last_q;
	logic [1:0] wgt_q;
	logic          fl_s1;
	logic [AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rib_q  <= '0;
			coff_q <= '0;
			roff_q <= '0;
			oc_q   <= '0;
			ocnt_q <= '0;
		end else if (cfg_we) begin
			col_q  <= '0;
			row_q  <= '0;
			rib_q  <= '0;
			coff_q <= '0;
			roff_q <= '0;
			oc_q   <= '0;
			ocnt_q <= '0;
		end else if (cmd.load) begin
			if (14'(col_q) + 14'd1 >= w_eff) begin
				col_q  <= '0;
				coff_q <= '0;
				oc_q   <= '0;
				if (14'(row_q) + 14'd1 >= h_eff) begin
					row_q  <= '0;
					rib_q  <= '0;
					roff_q <= '0;
					ocnt_q <= '0;
				end else begin
					row_q <= row_q + 12'd1;
					rib_q <= (5'(rib_q) + 5'd1 >= 5'(f_eff)) ? 4'd0 : rib_q + 4'd1;
					if (roff_q + FW'(1) >= f_eff) begin
						roff_q <= '0;
						ocnt_q <= ocnt_q + 14'd1;
					end else begin
						roff_q <= roff_q + FW'(1);
					end
				end
			end else begin
				col_q <= col_q + 12'd1;
				if (coff_q + FW'(1) >= f_eff) begin
					coff_q <= '0;
					oc_q   <= oc_q + AW'(1);
				end else begin
					coff_q <= coff_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q[0] <= red_or_gray;
			px_q[1] <= rgb ? green : 8'd0;
			px_q[2] <= rgb ? blue : 8'd0;
			inb_q   <= (14'(col_q) < colend_q) && (14'(row_q) < rowend_q);
			first_q <= (rib_q == 4'd0) && (coff_q == '0);
			last_q  <= (coff_q == f_eff - FW'(1)) && (5'(rib_q) >= 5'(f_eff) - 5'd1);
			wgt_q   <= gauss ? {(coff_q == FW'(1)) && (rib_q == 4'd1),
				(coff_q == FW'(1)) ^ (rib_q == 4'd1)} : 2'd0;
			fl_s1   <= (14'(oc_q) == ow_q - 14'd1) && (ocnt_q == oh_q - 14'd1);
			addr_s1 <= oc_q;
		end
	end

	logic [47:0]   rd, wd;
	logic [SUM_W-1:0] sum [3];

	ibd_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_WIDTH)) u_sums (
		.clk   (clk),
		.we    (cmd.update && inb_q),
		.waddr (addr_s1),
		.wdata (wd),
		.raddr (addr_s1),
		.rdata (rd)
	);

	// weight: 1, 2 or 4 -> shift
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = (first_q ? 16'd0 : rd[SUM_W*c +: SUM_W])
				+ (16'(px_q[c]) << (wgt_q[1] ? 2 : (wgt_q[0] ? 1 : 0)));
		end
		wd = {sum[2], sum[1], sum[0]};
	end

	assign stat.in_block = inb_q;
	assign stat.emit     = inb_q && last_q;
	assign stat.out_busy = out_valid && out_stall;

	// divider: restoring, one quotient bit per cycle, three channels in parallel; factor 3 shifts instead
	localparam int QB = SUM_W;
	logic [SUM_W-1:0] num_q [3];
	logic [SUM_W:0]   rem_q [3];
	logic [DW-1:0]    div_q;
	logic [4:0]       bit_q;
	logic             dbusy_q, dgauss_q, fl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q   <= 1'b0;
			bit_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				bit_q   <= 5'(QB);
			end else if (dbusy_q) begin
				if (dgauss_q || bit_q == 5'd0) begin
					dbusy_q   <= 1'b0;
					out_valid <= 1'b1;
				end
				bit_q <= bit_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= sum[c];
				rem_q[c] <= '0;
			end
			div_q    <= DW'(f_eff) * DW'(f_eff);
			dgauss_q <= gauss;
			fl_q     <= fl_s1;
		end else if (dbusy_q) begin
			for (int c = 0; c < 3; c++) begin
				if (dgauss_q) begin
					num_q[c] <= num_q[c] >> GAUSS_SHIFT;
				end else begin
					if ({rem_q[c][SUM_W-1:0], num_q[c][SUM_W-1]} >= (SUM_W+1)'(div_q)) begin
						rem_q[c] <= {rem_q[c][SUM_W-1:0], num_q[c][SUM_W-1]}
							- (SUM_W+1)'(div_q);
						num_q[c] <= {num_q[c][SUM_W-2:0], 1'b1};
					end else begin
						rem_q[c] <= {rem_q[c][SUM_W-1:0], num_q[c][SUM_W-1]};
						num_q[c] <= {num_q[c][SUM_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign stat.div_done = dbusy_q && (dgauss_q || bit_q == 5'd0);

	function automatic logic [7:0] sat8(input logic [SUM_W-1:0] v);
		return (v > 16'd255) ? 8'd255 : v[7:0];
	endfunction

	logic [7:0] ro_q, go_q, bo_q;
	logic       flo_q;
	always_ff @(posedge clk) begin
		if (stat.div_done) begin
			ro_q  <= sat8(dgauss_q ? num_q[0] >> GAUSS_SHIFT : num_q[0]);
			go_q  <= sat8(dgauss_q ? num_q[1] >> GAUSS_SHIFT : num_q[1]);
			bo_q  <= sat8(dgauss_q ? num_q[2] >> GAUSS_SHIFT : num_q[2]);
			flo_q <= fl_q;
		end
	end

	assign out_red_or_gray = ro_q;
	assign out_green       = go_q;
	assign out_blue        = bo_q;
	assign frame_last      = flo_q;

	`ASSERT_IMPL(a_div_free, clk, arst_n, cmd.div_start |-> !dbusy_q, "divide restarted while busy")
	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, stat.div_done |-> !out_valid || !out_stall, "result overwritten")
	`ASSERT_NEXT(a_done_valid, clk, arst_n, stat.div_done, out_valid, "result not shown")
endmodule

// ===== hdl/image_block_downscaler.sv =====
// Top level of the image block downscaler.
// Pixels enter one word at a time in raster order; each complete factor-by-factor
// block gives one output word (block mean, or 1-2-1 Gaussian sum over 16 for
// factor 3). Each item goes through capture, column-sum read and update; an item
// that closes a block then runs the divider, one quotient bit per cycle (a shift
// for factor 3). After reset and after any configuration write, a sizing pass
// counts the whole blocks across the width and then the height; items arriving
// then are held off. Configuration writes restart the frame position.
module image_block_downscaler #(
	parameter int MAX_WIDTH  = ibd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = ibd_pkg::MAX_FACTOR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_or_gray,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red_or_gray,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_last
);
	import ibd_pkg::*;

	ibd_cmd_t  cmd;
	ibd_stat_t stat;

	// input stall also covers the sizing pass, reported by the datapath status
	ibd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	ibd_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_FACTOR(MAX_FACTOR)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.red_or_gray     (red_or_gray),
		.green           (green),
		.blue            (blue),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_red_or_gray (out_red_or_gray),
		.out_green       (out_green),
		.out_blue        (out_blue),
		.frame_last      (frame_last)
	);
endmodule

// ===== sim/downscale_checker.sv =====
// Checker for the image block downscaler: predicts output words and compares them.
module downscale_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  red_or_gray,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_red_or_gray,
	input  logic [7:0]  out_green,
	input  logic [7:0]  out_blue,
	input  logic        frame_last,
	output int          fail_count,
	output int          pending,
	output int          pixels_seen,
	output int          words_seen
);
	import ibd_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} pix_out_t;

	logic        mode_rgb;
	logic [4:0]  factor_reg;
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	logic [47:0] col_acc [MAX_WIDTH_DEF];
	int unsigned col_pos, row_pos, row_off;
	pix_out_t    expected_pix [$];

	function automatic int unsigned clamp_lim(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// advance the position and push an expected word when a block closes
	task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned f, w, h, ow, oh, oc, coff, wt, dv, s, v;
		logic [47:0] acc;
		logic [15:0] part;
		logic [7:0]  px [3];
		pix_out_t    p;
		f = clamp_lim(factor_reg, MAX_FACTOR_DEF);
		w = clamp_lim(width_reg, MAX_WIDTH_DEF);
		h = clamp_lim(height_reg, HEIGHT_LIMIT);
		ow = w / f;
		oh = h / f;
		px[0] = r;
		px[1] = mode_rgb ? g : 8'd0;
		px[2] = mode_rgb ? b : 8'd0;
		if (col_pos < ow * f && row_pos < oh * f) begin
			oc = col_pos / f;
			coff = col_pos % f;
			wt = 1;
			if (f == GAUSS_FACTOR)
				wt = (coff == 1 ? 2 : 1) * (row_off == 1 ? 2 : 1);
			acc = (row_off == 0 && coff == 0) ? 48'd0 : col_acc[oc];
			for (int ch = 0; ch < 3; ch++) begin
				part = acc[16*ch +: 16] + 16'(px[ch] * wt);
				acc[16*ch +: 16] = part;
			end
			col_acc[oc] = acc;
			if (coff == f - 1 && row_off >= f - 1) begin
				dv = (f == GAUSS_FACTOR) ? 16 : f * f;
				for (int ch = 0; ch < 3; ch++) begin
					s = acc[16*ch +: 16];
					v = s / dv;
					if (v > 255) v = 255;
					px[ch] = (mode_rgb || ch == 0) ? 8'(v) : 8'd0;
				end
				p.r = px[0];
				p.g = px[1];
				p.b = px[2];
				p.last = (oc == ow - 1 && row_pos / f == oh - 1);
				expected_pix.push_back(p);
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				row_off = 0;
			end else begin
				row_pos++;
				row_off = (row_off + 1 >= f) ? 0 : row_off + 1;
			end
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t p;
		if (!arst_n) begin
			mode_rgb <= 1'b0;
			factor_reg <= 5'd2;
			width_reg <= 13'd1;
			height_reg <= 13'd1;
			col_pos = 0;
			row_pos = 0;
			row_off = 0;
			fail_count <= 0;
			pixels_seen <= 0;
			words_seen <= 0;
			expected_pix.delete();
		end else begin
			// compare the output word against the oldest prediction
			if (out_valid && !out_stall) begin
				words_seen <= words_seen + 1;
				if (expected_pix.size() == 0) begin
					if (fail_count < 10)
						$display("mismatch: unexpected output word %0h %0h %0h last %0b",
							out_red_or_gray, out_green, out_blue, frame_last);
					fail_count <= fail_count + 1;
				end else begin
					p = expected_pix.pop_front();
					if (p.r !== out_red_or_gray || p.g !== out_green ||
					    p.b !== out_blue || p.last !== frame_last) begin
						if (fail_count < 10)
							$display("mismatch: expected %0h %0h %0h last %0b, got %0h %0h %0h last %0b",
								p.r, p.g, p.b, p.last,
								out_red_or_gray, out_green, out_blue, frame_last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_pixel(red_or_gray, green, blue);
				pixels_seen <= pixels_seen + 1;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_COLOR:  mode_rgb <= cfg_data[0];
					REG_FACTOR: factor_reg <= cfg_data[4:0];
					REG_WIDTH:  width_reg <= cfg_data;
					REG_HEIGHT: height_reg <= cfg_data;
				endcase
				col_pos = 0;
				row_pos = 0;
				row_off = 0;
			end
		end
	end

	assign pending = expected_pix.size();
endmodule

// ===== sim/testbench.sv =====
// Top of the downscaler testbench: stimulus, configuration phases and verdict.
module testbench;
	import ibd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_COLOR;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  red_or_gray = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_red_or_gray, out_green, out_blue;
	logic        frame_last;
	int          fail_count, pending, pixels_seen, words_seen;
	int unsigned cycle_count = 0;
	bit          quiet_phase = 1'b0;
	int          frames_run = 0;

	// worst pixel: capture, read, update and divide, random stall gaps both sides, plus sizing passes
	localparam int unsigned CYCLE_LIMIT = 1_500_000;

	always #5 clk = ~clk;

	image_block_downscaler dut (.*);
	downscale_checker chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stall: random bursts, none in the quiet tail
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// drive one write; the caller drops the enable after the last one
	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// drain outputs, wait out a divide and sizing pass, then configure
	task automatic set_frame(bit rgb, logic [4:0] f, logic [12:0] w, logic [12:0] h);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		write_reg(REG_COLOR, 13'(rgb));
		write_reg(REG_FACTOR, 13'(f));
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_we <= 1'b0;
		frames_run++;
	endtask

	// hand one word over; hold the payload while stalled, keep valid up for the next word
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int n;
		if (!quiet_phase && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_or_gray <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(int count, int style);
		logic [7:0] v;
		for (int i = 0; i < count; i++) begin
			v = 8'($urandom);
			case (style)
				0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				1: send_pixel(8'hFF, 8'hFF, 8'hFF);
				default: send_pixel(v, ~v, 8'h00);
			endcase
		end
	endtask

	initial begin
		int w, h, f, total, n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults (1x1 image, no output), then extremes
		send_pixel(8'hFF, 8'h00, 8'hAA);
		set_frame(1'b1, 5'd2, 13'd4, 13'd2);
		send_random(8, 1);
		set_frame(1'b1, 5'd3, 13'd3, 13'd3);
		send_random(9, 1);
		set_frame(1'b0, 5'd1, 13'd3, 13'd1);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h55, 8'h55);
		send_pixel(8'h80, 8'h01, 8'h01);
		// factor zero acts as one; a factor above the maximum acts as the maximum
		set_frame(1'b1, 5'd0, 13'd0, 13'd0);
		send_random(2, 0);
		set_frame(1'b0, 5'd31, 13'd8, 13'd2);
		send_random(16, 0);
		// image smaller than a block gives nothing; a huge width gets clamped
		set_frame(1'b1, 5'd16, 13'd8191, 13'd1);
		send_random(4, 0);

		// random frames: mostly small, a few wide ones
		total = 0;
		while (total < 1800) begin
			if (total > 1450) quiet_phase = 1'b1;
			f = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(1, 5);
			if ($urandom_range(0, 25) == 0) f = 16;
			w = f * $urandom_range(1, 4) + $urandom_range(0, 2);
			h = f * $urandom_range(1, 3) + $urandom_range(0, 2);
			if (w * h > 200) h = 1 + 200 / w;
			set_frame(1'($urandom_range(0, 1)), 5'(f), 13'(w), 13'(h));
			n = w * h * $urandom_range(1, 2);
			send_random(n, $urandom_range(0, 9) == 0 ? 1 : 0);
			total += n;
			if ($urandom_range(0, 8) == 0) begin
				n = $urandom_range(1, w);
				send_random(n, 2);
				total += n;
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d frame settings, %0d pixels in, %0d words out",
			frames_run, pixels_seen, words_seen);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
